@@ hdl/chr_pkg.sv @@
// Shared types, constants and the command size table for the command history
// replay unit. No dependencies.

package chr_pkg;

  localparam int BUFFER_WORDS_DEF  = 16;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int MAX_RESULTS       = 64;
  localparam int MAX_TIMES         = 4;

  localparam int CODE_W   = 4;
  localparam int PCNT_W   = 4;
  localparam int WORD_W   = 16;
  localparam int RCNT_W   = 4;
  localparam int RTIMES_W = 3;
  localparam int NRES_W   = 7;

  typedef enum logic [1:0] {
    REQ_HEADER  = 2'd0,
    REQ_PARAM   = 2'd1,
    REQ_REPLAY  = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_EV_CHK, S_EV_OFF, S_EV_WORD, S_STORE, S_PARAM, S_BADREQ,
    S_RP_INIT, S_RP_CMD, S_RP_POS, S_RP_NXT, S_RP_RD, S_RP_EMIT, S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    take;
    logic    hdr_start;
    logic    ev_rd_off;
    logic    ev_rd_word;
    logic    ev_shift;
    logic    store;
    logic    param;
    logic    rp_init;
    logic    rp_pass;
    logic    rp_skip;
    logic    rp_pos;
    logic    rp_rd_nxt;
    logic    rp_end;
    logic    rp_emit;
    logic    emit_st;
    status_t st;
    logic    finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_long;
    logic need_evict;
    logic none_held;
    logic off_past;
    logic pend_zero;
    logic param_blocked;
    logic rp_done;
    logic rp_cap;
    logic k_end;
    logic has_next;
    logic w_last;
    logic emit_ok;
    logic fin_ok;
  } dp_stat_t;

  // words taken by a command of the given stored header value
  function automatic logic [3:0] size_of(input logic [WORD_W-1:0] w);
    logic [3:0] sz;
    if (w[WORD_W-1:CODE_W] != '0) begin
      sz = 4'd1;
    end else begin
      unique case (w[CODE_W-1:0])
        4'd0, 4'd1: sz = 4'd2;
        4'd2:       sz = 4'd4;
        4'd3, 4'd4: sz = 4'd7;
        4'd5:       sz = 4'd5;
        4'd6:       sz = 4'd6;
        4'd7:       sz = 4'd12;
        4'd8:       sz = 4'd8;
        4'd9:       sz = 4'd4;
        default:    sz = 4'd1;
      endcase
    end
    return sz;
  endfunction

endpackage

@@ hdl/chr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module chr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hdl/chr_ctrl.sv @@
// Sequencing state machine of the command history replay unit.
// Depends on chr_pkg; drives chr_dp through dp_cmd_t.

module chr_ctrl import chr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_tuser,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.st    = ST_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            REQ_HEADER: state_nxt = S_HDR;
            REQ_PARAM:  state_nxt = S_PARAM;
            REQ_REPLAY: state_nxt = S_RP_INIT;
            default:    state_nxt = S_BADREQ;
          endcase
        end
      end
      S_HDR: begin
        cmd.hdr_start = 1'b1;
        if (stat.too_long) begin
          cmd.emit_st = 1'b1;
          cmd.st      = ST_INVALID;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (!stat.need_evict) begin
          state_nxt = S_STORE;
        end else if (stat.none_held) begin
          cmd.emit_st = 1'b1;
          cmd.st      = ST_DROPPED;
          state_nxt   = S_FIN;
        end else begin
          cmd.ev_rd_off = 1'b1;
          state_nxt     = S_EV_OFF;
        end
      end
      S_EV_OFF: begin
        if (stat.off_past) begin
          cmd.emit_st = 1'b1;
          cmd.st      = ST_DROPPED;
          state_nxt   = S_FIN;
        end else begin
          cmd.ev_rd_word = 1'b1;
          state_nxt      = S_EV_WORD;
        end
      end
      S_EV_WORD: begin
        cmd.ev_shift = 1'b1;
        state_nxt    = S_EV_CHK;
      end
      S_STORE: begin
        cmd.store   = 1'b1;
        cmd.emit_st = 1'b1;
        cmd.st      = ST_OK;
        state_nxt   = S_FIN;
      end
      S_PARAM: begin
        cmd.param   = 1'b1;
        cmd.emit_st = 1'b1;
        if (stat.pend_zero) begin
          cmd.st = ST_INVALID;
        end else if (stat.param_blocked) begin
          cmd.st = ST_DROPPED;
        end else begin
          cmd.st = ST_OK;
        end
        state_nxt = S_FIN;
      end
      S_BADREQ: begin
        cmd.emit_st = 1'b1;
        cmd.st      = ST_INVALID;
        state_nxt   = S_FIN;
      end
      S_RP_INIT: begin
        cmd.rp_init = 1'b1;
        state_nxt   = S_RP_CMD;
      end
      S_RP_CMD: begin
        if (stat.rp_done) begin
          state_nxt = S_FIN;
        end else if (stat.k_end) begin
          cmd.rp_pass = 1'b1;
        end else begin
          state_nxt = S_RP_POS;
        end
      end
      S_RP_POS: begin
        if (stat.off_past) begin
          cmd.rp_skip = 1'b1;
          state_nxt   = S_RP_CMD;
        end else begin
          cmd.rp_pos = 1'b1;
          if (stat.has_next) begin
            cmd.rp_rd_nxt = 1'b1;
            state_nxt     = S_RP_NXT;
          end else begin
            state_nxt = S_RP_RD;
          end
        end
      end
      S_RP_NXT: begin
        cmd.rp_end = 1'b1;
        state_nxt  = S_RP_RD;
      end
      S_RP_RD: begin
        state_nxt = S_RP_EMIT;
      end
      S_RP_EMIT: begin
        if (stat.rp_cap) begin
          state_nxt = S_FIN;
        end else if (stat.emit_ok) begin
          cmd.rp_emit = 1'b1;
          state_nxt   = stat.w_last ? S_RP_CMD : S_RP_RD;
        end
      end
      S_FIN: begin
        if (stat.fin_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/chr_dp.sv @@
// Datapath of the command history replay unit: word store, start offset
// store, fill and history counters, replay walk and output buffering.
// Depends on chr_pkg and chr_ram; controlled by chr_ctrl.

module chr_dp import chr_pkg::*; #(
  parameter int BUFFER_WORDS  = BUFFER_WORDS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int AW  = $clog2(BUFFER_WORDS);
  localparam int OW  = AW;
  localparam int WUW = $clog2(BUFFER_WORDS + 1);
  localparam int NW  = WUW + 1;
  localparam int HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int CMW = (HCW > RCNT_W) ? HCW : RCNT_W;

  // latched input item
  logic [CODE_W-1:0]   code_r;
  logic [PCNT_W-1:0]   pc_r;
  logic [WORD_W-1:0]   pword_r;
  logic [RCNT_W-1:0]   cnt_r;
  logic [RTIMES_W-1:0] times_r;

  // store bookkeeping
  logic [WUW-1:0]    wu_r, wu_nxt;
  logic [HCW-1:0]    held_r, held_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [OW-1:0]     bias_r, bias_nxt;
  logic [HW-1:0]     head_r, head_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic              drop_r, drop_nxt;

  // replay walk
  logic [HCW-1:0]      k_r, first_r;
  logic [RTIMES_W-1:0] h_r, t_r;
  logic [NRES_W-1:0]   n_r;
  logic [WUW-1:0]      w_r, pos_r, end_r;

  // pending result and output register
  logic              pend_v_r, pend_kind_r, pend_starts_r;
  status_t           pend_st_r;
  logic [WORD_W-1:0] pend_word_r;
  logic              out_v_r, out_kind_r, out_starts_r, out_last_r;
  status_t           out_st_r;
  logic [WORD_W-1:0] out_word_r;

  logic [WORD_W-1:0] word_rdata, word_wdata;
  logic [AW-1:0]     word_waddr, word_raddr;
  logic              word_we;
  logic [OW-1:0]     off_rdata, off_wdata;
  logic [HW-1:0]     off_waddr, off_raddr;

  logic [OW-1:0]     lo;
  logic [WUW-1:0]    lo_ext, szw, end_clip;
  logic [3:0]        sz0;
  logic [CMW-1:0]    cnt_min;
  logic              acc, e_v, e_kind, e_starts, emit_ok, fin_ok;
  status_t           e_st;
  logic [WORD_W-1:0] e_word;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [WUW-1:0] i);
    logic [WUW:0] s;
    s = (WUW+1)'(b) + (WUW+1)'(i);
    if (s >= (WUW+1)'(BUFFER_WORDS)) begin
      s = s - (WUW+1)'(BUFFER_WORDS);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [HW-1:0] slot(input logic [HW-1:0] hd, input logic [HCW-1:0] k);
    logic [HCW:0] s;
    s = (HCW+1)'(hd) + (HCW+1)'(k);
    if (s >= (HCW+1)'(HISTORY_DEPTH)) begin
      s = s - (HCW+1)'(HISTORY_DEPTH);
    end
    return s[HW-1:0];
  endfunction

  chr_ram #(.WIDTH(WORD_W), .DEPTH(BUFFER_WORDS), .AW(AW)) u_word_ram (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(word_wdata),
    .raddr(word_raddr), .rdata(word_rdata)
  );

  chr_ram #(.WIDTH(OW), .DEPTH(HISTORY_DEPTH), .AW(HW)) u_off_ram (
    .clk(clk), .we(cmd.store), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(off_raddr), .rdata(off_rdata)
  );

  assign acc = cmd.take && in_tvalid;

  // offsets are held relative to a running bias, so eviction never rewrites them
  assign lo     = off_rdata - bias_r;
  assign lo_ext = WUW'(lo);

  assign word_we    = cmd.store || (cmd.param && (pcnt_r != '0) && !stat.param_blocked);
  assign word_waddr = phys(base_r, wu_r);
  assign word_wdata = cmd.store ? WORD_W'(code_r) : pword_r;
  assign word_raddr = cmd.ev_rd_word ? phys(base_r, lo_ext) : phys(base_r, w_r);

  assign off_waddr = slot(head_r, held_r);
  assign off_wdata = OW'(wu_r) + bias_r;
  assign off_raddr = cmd.ev_rd_off ? head_r :
                     cmd.rp_rd_nxt ? slot(head_r, k_r + 1'b1) : slot(head_r, k_r);

  assign sz0      = size_of(word_rdata);
  assign szw      = (WUW'(sz0) > wu_r) ? WUW'(1) : WUW'(sz0);
  assign cnt_min  = (CMW'(cnt_r) > CMW'(held_r)) ? CMW'(held_r) : CMW'(cnt_r);
  assign end_clip = (lo_ext > wu_r) ? wu_r : lo_ext;

  assign emit_ok = !pend_v_r || !out_v_r || out_tready;
  assign fin_ok  = !out_v_r || out_tready;

  always_comb begin
    stat.too_long      = (NW'(pc_r) + NW'(1)) > NW'(BUFFER_WORDS);
    stat.need_evict    = (held_r >= HCW'(HISTORY_DEPTH)) ||
                         ((NW'(wu_r) + NW'(1) + NW'(pc_r)) > NW'(BUFFER_WORDS));
    stat.none_held     = (held_r == '0);
    stat.off_past      = (lo_ext >= wu_r);
    stat.pend_zero     = (pcnt_r == '0);
    stat.param_blocked = drop_r || (wu_r >= WUW'(BUFFER_WORDS));
    stat.rp_cap        = (n_r >= NRES_W'(MAX_RESULTS));
    stat.rp_done       = stat.rp_cap || (h_r >= t_r);
    stat.k_end         = (k_r >= held_r);
    stat.has_next      = ((HCW+1)'(k_r) + 1'b1) < (HCW+1)'(held_r);
    stat.w_last        = ((w_r + 1'b1) >= end_r);
    stat.emit_ok       = emit_ok;
    stat.fin_ok        = fin_ok;
  end

  // bookkeeping next state
  always_comb begin
    wu_nxt   = wu_r;
    held_nxt = held_r;
    base_nxt = base_r;
    bias_nxt = bias_r;
    head_nxt = head_r;
    pcnt_nxt = pcnt_r;
    drop_nxt = drop_r;
    if (cmd.hdr_start) begin
      pcnt_nxt = pc_r;
      drop_nxt = 1'b1;
    end
    if (cmd.ev_shift) begin
      wu_nxt   = wu_r - szw;
      held_nxt = held_r - 1'b1;
      base_nxt = phys(base_r, szw);
      bias_nxt = bias_r + OW'(szw);
      head_nxt = (head_r == HW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (cmd.store) begin
      wu_nxt   = wu_r + 1'b1;
      held_nxt = held_r + 1'b1;
      drop_nxt = 1'b0;
    end
    if (cmd.param && (pcnt_r != '0)) begin
      pcnt_nxt = pcnt_r - 1'b1;
      if (!stat.param_blocked) begin
        wu_nxt = wu_r + 1'b1;
      end
    end
    if (pcnt_nxt == '0) begin
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wu_r   <= '0;
      held_r <= '0;
      base_r <= '0;
      bias_r <= '0;
      head_r <= '0;
      pcnt_r <= '0;
      drop_r <= 1'b0;
    end else begin
      wu_r   <= wu_nxt;
      held_r <= held_nxt;
      base_r <= base_nxt;
      bias_r <= bias_nxt;
      head_r <= head_nxt;
      pcnt_r <= pcnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  // input latch and replay walk registers
  always_ff @(posedge clk) begin
    if (acc) begin
      code_r  <= in_tdata[3:0];
      pc_r    <= in_tdata[7:4];
      pword_r <= in_tdata[23:8];
      cnt_r   <= in_tdata[27:24];
      times_r <= in_tdata[30:28];
    end
    if (cmd.rp_init) begin
      t_r     <= (times_r > RTIMES_W'(MAX_TIMES)) ? RTIMES_W'(MAX_TIMES) : times_r;
      first_r <= held_r - HCW'(cnt_min);
      k_r     <= held_r - HCW'(cnt_min);
      h_r     <= '0;
      n_r     <= '0;
    end
    if (cmd.rp_pass) begin
      h_r <= h_r + 1'b1;
      k_r <= first_r;
    end
    if (cmd.rp_skip) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.rp_pos) begin
      pos_r <= lo_ext;
      w_r   <= lo_ext;
      end_r <= wu_r;
    end
    if (cmd.rp_end) begin
      end_r <= (end_clip <= pos_r) ? pos_r + 1'b1 : end_clip;
    end
    if (cmd.rp_emit) begin
      n_r <= n_r + 1'b1;
      w_r <= w_r + 1'b1;
      if (stat.w_last) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // result candidate
  always_comb begin
    e_v      = cmd.emit_st || cmd.rp_emit;
    e_kind   = cmd.rp_emit;
    e_st     = cmd.rp_emit ? ST_OK : cmd.st;
    e_word   = cmd.rp_emit ? word_rdata : '0;
    e_starts = cmd.rp_emit && (w_r == pos_r);
  end

  // one result is held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (cmd.finish) begin
      out_v_r      <= 1'b1;
      out_last_r   <= 1'b1;
      out_kind_r   <= pend_v_r && pend_kind_r;
      out_st_r     <= pend_v_r ? pend_st_r : ST_OK;
      out_word_r   <= pend_v_r ? pend_word_r : '0;
      out_starts_r <= pend_v_r && pend_starts_r;
      pend_v_r     <= 1'b0;
    end else if (e_v) begin
      if (pend_v_r) begin
        out_v_r      <= 1'b1;
        out_last_r   <= 1'b0;
        out_kind_r   <= pend_kind_r;
        out_st_r     <= pend_st_r;
        out_word_r   <= pend_word_r;
        out_starts_r <= pend_starts_r;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      pend_v_r      <= 1'b1;
      pend_kind_r   <= e_kind;
      pend_st_r     <= e_st;
      pend_word_r   <= e_word;
      pend_starts_r <= e_starts;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_word_r, out_st_r};
  assign out_tuser  = {out_starts_r, out_kind_r};
  assign out_tlast  = out_last_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HCW'(HISTORY_DEPTH))
    else $error("history count above depth");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wu_r <= WUW'(BUFFER_WORDS))
    else $error("fill level above buffer size");

  a_drop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (pcnt_r != '0))
    else $error("dropping with no parameters pending");

  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_v_r && out_last_r && !pend_v_r))
    else $error("finish did not present a last transfer");

endmodule

@@ hdl/command_history_replay_unit.sv @@
// Top level of the command history replay unit.
// Depends on chr_pkg, chr_ctrl, chr_dp (which holds two chr_ram stores).
//
// Records variable-length drawing commands (a header word holding the type
// code, then its parameter words) in a circular word store, evicting the oldest
// commands before a new header when the history is full or the word space is
// too small for it, and replays the newest N commands T times on request.
//
// Input channel (in_): one transfer per item; in_tuser carries the request
// kind (header, parameter word, replay). Output channel (out_): each item
// yields one or more transfers, out_tlast marks its final one. Record items
// give a single status transfer; a replay gives the replayed words (at most
// 64) or one status transfer when nothing is replayed.
//
// One item is worked at a time. A header is checked, then evicts the oldest
// commands one by one and is stored; a replay walks each pass over the
// selected commands, reading each word from the word store RAM before it is
// emitted, so replayed words are not emitted back to back. One result is held
// back in a pending stage so the last transfer can be flagged; behind it sits
// the output register, so the next item is accepted while the final result
// still waits. When out_tready is low the replay walk holds until the output
// register frees. Synchronous reset empties the history; store contents stay
// unwritten until filled.

module command_history_replay_unit import chr_pkg::*; #(
  parameter int BUFFER_WORDS  = BUFFER_WORDS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd_code[3:0], arg_count[7:4], param_word[23:8],
                                  // replay_commands[27:24], replay_times[30:28]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[1:0], word[17:2]
  output logic [1:0]  out_tuser,  // result_kind[0], starts_command[1]
  output logic        out_tlast   // last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  chr_dp #(
    .BUFFER_WORDS  (BUFFER_WORDS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  // input transfers are taken only between items
  assign in_tready = cmd.take;

endmodule
